// ===== rtl/pit_pkg.sv =====
package pit_pkg;

    // Default coordinate width of the corner and point fields.
    localparam int COORD_BITS_DEF = 16;

    // Width of one unsigned limb in the limb-product multipliers.
    localparam int LIMB_BITS = 18;

    // Verdict flags that travel beside the numbers through the back end.
    typedef struct packed {
        logic degen;
        logic reject;
    } t_side;

    // Edge vectors u, v, w: one bit more than a coordinate.
    function automatic int diff_bits(input int n);
        return n + 1;
    endfunction

    // Width of a cross-product component of the edge vectors.
    function automatic int cross_bits(input int n);
        return 2 * diff_bits(n) + 1;
    endfunction

    // Dot product of two cross products: three products summed.
    function automatic int dot_bits(input int n);
        return 2 * cross_bits(n) + 2;
    endfunction

    // Room for c - a - b.
    function automatic int ext_bits(input int n);
        return dot_bits(n) + 1;
    endfunction

    // Register count of one limb-product multiplier of w-bit operands.
    function automatic int mul_latency(input int w);
        int nl;
        nl = (w + LIMB_BITS - 1) / LIMB_BITS;
        return $clog2(nl * nl) + 3;
    endfunction

    // Register count from an accepted item to its result strobe.
    function automatic int pit_latency(input int n);
        return 3 + mul_latency(cross_bits(n)) + 2 + mul_latency(ext_bits(n)) + 1;
    endfunction

endpackage

// ===== rtl/point_in_triangle_test.sv =====
// Channel  Dir  Handshake         Payload
// -------  ---  ----------------  ----------------------------------------
// item     in   start, busy       i_a_* i_b_* i_c_* i_p_* (x, y, z each)
// result   out  o_strobe          o_inside_res, o_degenerate
//
// One item is taken in every clock cycle while reset is released, and each
// result passes the cross, dot and judge stages in turn, through the
// limb-product multipliers of the latter two.
// Reset is synchronous and active low; it clears every valid bit, and busy
// is high only while reset is held. The receiver cannot stall, so results
// leave on a fixed schedule and the pipeline never holds.
module point_in_triangle_test #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    input  logic signed [COORD_BITS-1:0] i_p_x,
    input  logic signed [COORD_BITS-1:0] i_p_y,
    input  logic signed [COORD_BITS-1:0] i_p_z,
    output logic                         o_strobe,
    output logic                         o_inside_res,
    output logic                         o_degenerate
);
    import pit_pkg::*;

    localparam int X = cross_bits(COORD_BITS);
    localparam int E = ext_bits(COORD_BITS);

    logic signed [COORD_BITS-1:0] w_crd [12];
    logic                         w_take;
    logic                         w_xvld;
    logic signed [X-1:0]          w_vw [3];
    logic signed [X-1:0]          w_uw [3];
    logic signed [X-1:0]          w_uv [3];
    logic                         w_dvld;
    logic signed [E-1:0]          w_a;
    logic signed [E-1:0]          w_b;
    logic signed [E-1:0]          w_d;
    t_side                        w_flags;

    // The pipeline never pushes back; an item is only refused in reset.
    assign busy   = !i_rst_n;
    assign w_take = start && !busy;

    assign w_crd[0]  = i_a_x;
    assign w_crd[1]  = i_a_y;
    assign w_crd[2]  = i_a_z;
    assign w_crd[3]  = i_b_x;
    assign w_crd[4]  = i_b_y;
    assign w_crd[5]  = i_b_z;
    assign w_crd[6]  = i_c_x;
    assign w_crd[7]  = i_c_y;
    assign w_crd[8]  = i_c_z;
    assign w_crd[9]  = i_p_x;
    assign w_crd[10] = i_p_y;
    assign w_crd[11] = i_p_z;

    // Front end: edge vectors u = B - A, v = C - A, w = P - A and the cross
    // products v x w, u x w and u x v over three register stages.
    pit_cross #(.N(COORD_BITS)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_crd   (w_crd),
        .o_valid (w_xvld),
        .o_vw    (w_vw),
        .o_uw    (w_uw),
        .o_uv    (w_uv)
    );

    // Middle: the two same-side products, the squared norms a, b, c, and
    // d = c - a - b. A zero u x v marks the triangle as degenerate.
    pit_dot #(.N(COORD_BITS)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xvld),
        .i_vw    (w_vw),
        .i_uw    (w_uw),
        .i_uv    (w_uv),
        .o_valid (w_dvld),
        .o_a     (w_a),
        .o_b     (w_b),
        .o_d     (w_d),
        .o_flags (w_flags)
    );

    // Back end: the exact form of |v x w| + |u x w| <= |u x v|, which is
    // d >= 0 and 4ab <= d squared, with the verdict registered at the ports.
    pit_judge #(.N(COORD_BITS)) u_judge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dvld),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_d      (w_d),
        .i_flags  (w_flags),
        .o_strobe (o_strobe),
        .o_inside (o_inside_res),
        .o_degen  (o_degenerate)
    );

endmodule

// ===== rtl/pit_mul.sv =====
module pit_mul #(
    parameter int W      = 35,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic signed [2*W-1:0] o_p,
    output logic [SIDE_W-1:0]     o_side
);
    import pit_pkg::*;

    localparam int NL  = (W + LIMB_BITS - 1) / LIMB_BITS;
    localparam int MW  = NL * LIMB_BITS;
    localparam int NP  = NL * NL;
    localparam int TL  = $clog2(NP);
    localparam int PP  = 1 << TL;
    localparam int PW  = 2 * MW;
    localparam int PL  = 2 * LIMB_BITS;
    localparam int LAT = TL + 3;

    logic signed [MW-1:0]   w_ext_a;
    logic signed [MW-1:0]   w_ext_b;
    logic [MW-1:0]          r_mag_a;
    logic [MW-1:0]          r_mag_b;
    logic [PL-1:0]          r_pp [NP];
    logic [PW-1:0]          w_leaf [PP];
    logic [PW-1:0]          w_sum;
    logic signed [2*W-1:0]  r_p;
    logic [LAT-1:0]         r_vld;
    logic [SIDE_W:0]        r_sd [LAT];

    // Sign-magnitude front end: the limb products work on magnitudes.
    assign w_ext_a = MW'(i_a);
    assign w_ext_b = MW'(i_b);

    always_ff @(posedge i_clk) begin
        r_mag_a <= w_ext_a[MW-1] ? -w_ext_a : w_ext_a;
        r_mag_b <= w_ext_b[MW-1] ? -w_ext_b : w_ext_b;
    end

    for (genvar gi = 0; gi < NL; gi++) begin : g_row
        for (genvar gj = 0; gj < NL; gj++) begin : g_col
            always_ff @(posedge i_clk) begin
                r_pp[gi*NL+gj] <= PL'(r_mag_a[gi*LIMB_BITS +: LIMB_BITS])
                                * PL'(r_mag_b[gj*LIMB_BITS +: LIMB_BITS]);
            end
        end
    end

    for (genvar gx = 0; gx < PP; gx++) begin : g_leaf
        if (gx < NP) begin : g_used
            localparam int LI = gx / NL;
            localparam int LJ = gx % NL;
            assign w_leaf[gx] = PW'(r_pp[gx]) << ((LI + LJ) * LIMB_BITS);
        end else begin : g_pad
            assign w_leaf[gx] = '0;
        end
    end

    // Registered adder tree in heap order; node 0 is the root.
    if (TL > 0) begin : g_tree
        logic [PW-1:0] r_node [PP-1];
        for (genvar gn = 0; gn < PP - 1; gn++) begin : g_node
            localparam int LC = 2 * gn + 1;
            localparam int RC = 2 * gn + 2;
            logic [PW-1:0] w_l;
            logic [PW-1:0] w_r;
            if (LC >= PP - 1) begin : g_from_leaf
                assign w_l = w_leaf[LC-(PP-1)];
                assign w_r = w_leaf[RC-(PP-1)];
            end else begin : g_from_node
                assign w_l = r_node[LC];
                assign w_r = r_node[RC];
            end
            always_ff @(posedge i_clk) begin
                r_node[gn] <= w_l + w_r;
            end
        end
        assign w_sum = r_node[0];
    end else begin : g_flat
        assign w_sum = w_leaf[0];
    end

    always_ff @(posedge i_clk) begin
        r_p <= r_sd[LAT-2][SIDE_W] ? -w_sum[2*W-1:0] : w_sum[2*W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= {i_a[W-1] ^ i_b[W-1], i_side};
        for (int k = 1; k < LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_p     = r_p;
    assign o_side  = r_sd[LAT-1][SIDE_W-1:0];

endmodule

// ===== rtl/pit_cross.sv =====
module pit_cross #(
    parameter int N = pit_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [N-1:0]                      i_crd [12],
    output logic                                     o_valid,
    output logic signed [pit_pkg::cross_bits(N)-1:0] o_vw [3],
    output logic signed [pit_pkg::cross_bits(N)-1:0] o_uw [3],
    output logic signed [pit_pkg::cross_bits(N)-1:0] o_uv [3]
);
    import pit_pkg::*;

    localparam int D = diff_bits(N);
    localparam int X = cross_bits(N);

    logic signed [D-1:0]   r_u [3];
    logic signed [D-1:0]   r_v [3];
    logic signed [D-1:0]   r_w [3];
    logic signed [2*D-1:0] r_vw_l [3];
    logic signed [2*D-1:0] r_vw_r [3];
    logic signed [2*D-1:0] r_uw_l [3];
    logic signed [2*D-1:0] r_uw_r [3];
    logic signed [2*D-1:0] r_uv_l [3];
    logic signed [2*D-1:0] r_uv_r [3];
    logic signed [X-1:0]   r_vw [3];
    logic signed [X-1:0]   r_uw [3];
    logic signed [X-1:0]   r_uv [3];
    logic [2:0]            r_vld;

    for (genvar gk = 0; gk < 3; gk++) begin : g_comp
        localparam int K1 = (gk + 1) % 3;
        localparam int K2 = (gk + 2) % 3;

        always_ff @(posedge i_clk) begin
            r_u[gk] <= D'(i_crd[3+gk]) - D'(i_crd[gk]);
            r_v[gk] <= D'(i_crd[6+gk]) - D'(i_crd[gk]);
            r_w[gk] <= D'(i_crd[9+gk]) - D'(i_crd[gk]);

            r_vw_l[gk] <= r_v[K1] * r_w[K2];
            r_vw_r[gk] <= r_v[K2] * r_w[K1];
            r_uw_l[gk] <= r_u[K1] * r_w[K2];
            r_uw_r[gk] <= r_u[K2] * r_w[K1];
            r_uv_l[gk] <= r_u[K1] * r_v[K2];
            r_uv_r[gk] <= r_u[K2] * r_v[K1];

            r_vw[gk] <= X'(r_vw_l[gk]) - X'(r_vw_r[gk]);
            r_uw[gk] <= X'(r_uw_l[gk]) - X'(r_uw_r[gk]);
            r_uv[gk] <= X'(r_uv_l[gk]) - X'(r_uv_r[gk]);
        end

        assign o_vw[gk] = r_vw[gk];
        assign o_uw[gk] = r_uw[gk];
        assign o_uv[gk] = r_uv[gk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];

endmodule

// ===== rtl/pit_dot.sv =====
module pit_dot #(
    parameter int N = pit_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [pit_pkg::cross_bits(N)-1:0] i_vw [3],
    input  logic signed [pit_pkg::cross_bits(N)-1:0] i_uw [3],
    input  logic signed [pit_pkg::cross_bits(N)-1:0] i_uv [3],
    output logic                                   o_valid,
    output logic signed [pit_pkg::ext_bits(N)-1:0] o_a,
    output logic signed [pit_pkg::ext_bits(N)-1:0] o_b,
    output logic signed [pit_pkg::ext_bits(N)-1:0] o_d,
    output pit_pkg::t_side                         o_flags
);
    import pit_pkg::*;

    localparam int X = cross_bits(N);
    localparam int S = dot_bits(N);
    localparam int E = ext_bits(N);

    // Dot products formed in parallel. The first is (v x w).(u x v), the
    // negation of the same-side product against v x u.
    localparam int DOT_E = 0;
    localparam int DOT_F = 1;
    localparam int DOT_A = 2;
    localparam int DOT_B = 3;
    localparam int DOT_C = 4;

    logic signed [X-1:0]   w_opl [5][3];
    logic signed [X-1:0]   w_opr [5][3];
    logic signed [2*X-1:0] w_prod [5][3];
    logic                  w_degen;
    logic                  w_mvld;
    logic                  w_mdeg;
    logic signed [S-1:0]   r_dot [5];
    logic                  r_deg1;
    logic [1:0]            r_vld;
    logic signed [E-1:0]   r_a;
    logic signed [E-1:0]   r_b;
    logic signed [E-1:0]   r_d;
    t_side                 r_flags;

    assign w_degen = ~|{i_uv[0], i_uv[1], i_uv[2]};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_opl[DOT_E][k] = i_vw[k];
            w_opr[DOT_E][k] = i_uv[k];
            w_opl[DOT_F][k] = i_uw[k];
            w_opr[DOT_F][k] = i_uv[k];
            w_opl[DOT_A][k] = i_vw[k];
            w_opr[DOT_A][k] = i_vw[k];
            w_opl[DOT_B][k] = i_uw[k];
            w_opr[DOT_B][k] = i_uw[k];
            w_opl[DOT_C][k] = i_uv[k];
            w_opr[DOT_C][k] = i_uv[k];
        end
    end

    for (genvar gd = 0; gd < 5; gd++) begin : g_dot
        for (genvar gk = 0; gk < 3; gk++) begin : g_term
            if (gd == 0 && gk == 0) begin : g_lead
                pit_mul #(.W(X), .SIDE_W(1)) u_mul (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (i_valid),
                    .i_a     (w_opl[gd][gk]),
                    .i_b     (w_opr[gd][gk]),
                    .i_side  (w_degen),
                    .o_valid (w_mvld),
                    .o_p     (w_prod[gd][gk]),
                    .o_side  (w_mdeg)
                );
            end else begin : g_follow
                pit_mul #(.W(X), .SIDE_W(1)) u_mul (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_valid (i_valid),
                    .i_a     (w_opl[gd][gk]),
                    .i_b     (w_opr[gd][gk]),
                    .i_side  (w_degen),
                    .o_valid (),
                    .o_p     (w_prod[gd][gk]),
                    .o_side  ()
                );
            end
        end

        always_ff @(posedge i_clk) begin
            r_dot[gd] <= S'(w_prod[gd][0]) + S'(w_prod[gd][1]) + S'(w_prod[gd][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg1         <= w_mdeg;
        r_a            <= E'(r_dot[DOT_A]);
        r_b            <= E'(r_dot[DOT_B]);
        r_d            <= E'(r_dot[DOT_C]) - E'(r_dot[DOT_A]) - E'(r_dot[DOT_B]);
        r_flags.degen  <= r_deg1;
        r_flags.reject <= (!r_dot[DOT_E][S-1] && (r_dot[DOT_E] != '0))
                        || r_dot[DOT_F][S-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], w_mvld};
        end
    end

    assign o_valid = r_vld[1];
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_d     = r_d;
    assign o_flags = r_flags;

endmodule

// ===== rtl/pit_judge.sv =====
module pit_judge #(
    parameter int N = pit_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [pit_pkg::ext_bits(N)-1:0] i_a,
    input  logic signed [pit_pkg::ext_bits(N)-1:0] i_b,
    input  logic signed [pit_pkg::ext_bits(N)-1:0] i_d,
    input  pit_pkg::t_side                         i_flags,
    output logic                                   o_strobe,
    output logic                                   o_inside,
    output logic                                   o_degen
);
    import pit_pkg::*;

    localparam int E  = ext_bits(N);
    localparam int SW = $bits(t_side);

    t_side                 w_side_in;
    logic [SW-1:0]         w_side_out;
    t_side                 w_side;
    logic                  w_mvld;
    logic signed [2*E-1:0] w_ab;
    logic signed [2*E-1:0] w_dd;
    logic [2*E-1:0]        w_ab4;
    logic                  r_strobe;
    logic                  r_inside;
    logic                  r_degen;

    // A negative c - a - b already fails, so fold it into the reject flag.
    always_comb begin
        w_side_in        = i_flags;
        w_side_in.reject = i_flags.reject | i_d[E-1];
    end

    pit_mul #(.W(E), .SIDE_W(SW)) u_mul_ab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_a     (i_a),
        .i_b     (i_b),
        .i_side  (w_side_in),
        .o_valid (w_mvld),
        .o_p     (w_ab),
        .o_side  (w_side_out)
    );

    pit_mul #(.W(E), .SIDE_W(SW)) u_mul_dd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_a     (i_d),
        .i_b     (i_d),
        .i_side  (w_side_in),
        .o_valid (),
        .o_p     (w_dd),
        .o_side  ()
    );

    assign w_side = t_side'(w_side_out);
    assign w_ab4  = {w_ab[2*E-3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        r_inside <= !w_side.degen && !w_side.reject && ($unsigned(w_dd) >= w_ab4);
        r_degen  <= w_side.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_mvld;
        end
    end

    assign o_strobe = r_strobe;
    assign o_inside = r_inside;
    assign o_degen  = r_degen;

endmodule

// ===== rtl/pit_chk.sv =====
module pit_chk #(
    parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [COORD_BITS-1:0] i_a_x,
    input logic signed [COORD_BITS-1:0] i_a_y,
    input logic signed [COORD_BITS-1:0] i_a_z,
    input logic signed [COORD_BITS-1:0] i_b_x,
    input logic signed [COORD_BITS-1:0] i_b_y,
    input logic signed [COORD_BITS-1:0] i_b_z,
    input logic                         o_strobe,
    input logic                         o_inside_res,
    input logic                         o_degenerate
);
    import pit_pkg::*;

    localparam int LAT = pit_latency(COORD_BITS);
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] r_since;

    // Cycles since reset was released, saturating at the pipeline latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
        end else if (r_since != CW'(LAT)) begin
            r_since <= r_since + 1'b1;
        end
    end

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without a transfer at the pipeline latency");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_since == CW'(LAT) && $past(start && !busy, LAT)) |-> o_strobe)
        else $error("transfer did not produce a result at the pipeline latency");

    a_degen_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_degenerate) |-> !o_inside_res)
        else $error("degenerate triangle reported a point inside");

    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_strobe)
        else $error("result strobe right after reset");

    a_same_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_since == CW'(LAT) && $past(start && !busy && i_a_x == i_b_x
            && i_a_y == i_b_y && i_a_z == i_b_z, LAT))
        |-> (o_degenerate && !o_inside_res))
        else $error("coincident corners not reported as degenerate");

endmodule

bind point_in_triangle_test pit_chk #(.COORD_BITS(COORD_BITS)) u_pit_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_a_x        (i_a_x),
    .i_a_y        (i_a_y),
    .i_a_z        (i_a_z),
    .i_b_x        (i_b_x),
    .i_b_y        (i_b_y),
    .i_b_z        (i_b_z),
    .o_strobe     (o_strobe),
    .o_inside_res (o_inside_res),
    .o_degenerate (o_degenerate)
);

// ===== dv/pit_result_checker.sv =====
`timescale 1ns / 100ps

module pit_result_checker #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic signed [CW-1:0] i_a_x,
    input  logic signed [CW-1:0] i_a_y,
    input  logic signed [CW-1:0] i_a_z,
    input  logic signed [CW-1:0] i_b_x,
    input  logic signed [CW-1:0] i_b_y,
    input  logic signed [CW-1:0] i_b_z,
    input  logic signed [CW-1:0] i_c_x,
    input  logic signed [CW-1:0] i_c_y,
    input  logic signed [CW-1:0] i_c_z,
    input  logic signed [CW-1:0] i_p_x,
    input  logic signed [CW-1:0] i_p_y,
    input  logic signed [CW-1:0] i_p_z,
    input  logic                 o_strobe,
    input  logic                 o_inside_res,
    input  logic                 o_degenerate,
    output int                   fail_count,
    output int                   pending
);

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [255:0]  t_wide;

    typedef struct packed {
        logic in_tri;
        logic degen;
    } t_verdict;

    t_verdict expected_verdicts[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_wide dot3(input t_wide px, input t_wide py, input t_wide pz,
                                   input t_wide qx, input t_wide qy, input t_wide qz);
        return px * qx + py * qy + pz * qz;
    endfunction

    // Exact integer form of the barycentric test.
    function automatic t_verdict classify_point(
        input t_coord ax, input t_coord ay, input t_coord az,
        input t_coord bx, input t_coord by, input t_coord bz,
        input t_coord cx, input t_coord cy, input t_coord cz,
        input t_coord px, input t_coord py, input t_coord pz);
        t_wide ux, uy, uz, vx, vy, vz, wx, wy, wz;
        t_wide nx, ny, nz;
        t_wide vwx, vwy, vwz, uwx, uwy, uwz;
        t_wide na, nb, nc, gap;
        t_verdict res;
        ux = bx - ax;  uy = by - ay;  uz = bz - az;
        vx = cx - ax;  vy = cy - ay;  vz = cz - az;
        wx = px - ax;  wy = py - ay;  wz = pz - az;
        // Normal of the triangle, u x v.
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        res.in_tri = 1'b0;
        res.degen  = (nx == 0) && (ny == 0) && (nz == 0);
        if (res.degen)
            return res;
        vwx = vy * wz - vz * wy;
        vwy = vz * wx - vx * wz;
        vwz = vx * wy - vy * wx;
        uwx = uy * wz - uz * wy;
        uwy = uz * wx - ux * wz;
        uwz = ux * wy - uy * wx;
        // v x u is the negated normal.
        if (dot3(vwx, vwy, vwz, -nx, -ny, -nz) < 0)
            return res;
        if (dot3(uwx, uwy, uwz, nx, ny, nz) < 0)
            return res;
        na  = dot3(vwx, vwy, vwz, vwx, vwy, vwz);
        nb  = dot3(uwx, uwy, uwz, uwx, uwy, uwz);
        nc  = dot3(nx, ny, nz, nx, ny, nz);
        gap = nc - na - nb;
        if (gap < 0)
            return res;
        res.in_tri = (4 * na * nb) <= (gap * gap);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n === 1'b1) begin
            if (o_strobe !== 1'b0 && o_strobe !== 1'b1) begin
                report_mismatch("result strobe is unknown");
            end else if (o_strobe) begin
                got.in_tri = o_inside_res;
                got.degen  = o_degenerate;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.in_tri !== want.in_tri)
                        report_mismatch($sformatf("inside_res got %b want %b",
                                                  got.in_tri, want.in_tri));
                    if (got.degen !== want.degen)
                        report_mismatch($sformatf("degenerate got %b want %b",
                                                  got.degen, want.degen));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                expected_verdicts.push_back(classify_point(
                    i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z,
                    i_c_x, i_c_y, i_c_z, i_p_x, i_p_y, i_p_z));
            end
        end
        pending <= expected_verdicts.size();
    end

endmodule

// ===== dv/tb_point_in_triangle_test.sv =====
`timescale 1ns / 100ps

module tb_point_in_triangle_test;

    // Coordinate width of the block under test and its pipeline depth.
    localparam int CW         = pit_pkg::COORD_BITS_DEF;
    localparam int PIPE_LAT   = pit_pkg::pit_latency(CW);
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_ITEMS = 400;

    // Bounds of one signed coordinate.
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -(1 << (CW - 1));

    // Kinds of random item.
    typedef enum int {
        GEN_FULL,
        GEN_TINY,
        GEN_PLANAR,
        GEN_FLAT
    } t_gen_kind;

    typedef logic signed [CW-1:0] t_coord;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    logic   busy;
    t_coord i_a_x = '0, i_a_y = '0, i_a_z = '0;
    t_coord i_b_x = '0, i_b_y = '0, i_b_z = '0;
    t_coord i_c_x = '0, i_c_y = '0, i_c_z = '0;
    t_coord i_p_x = '0, i_p_y = '0, i_p_z = '0;
    logic   o_strobe;
    logic   o_inside_res;
    logic   o_degenerate;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // When set, the sender never inserts a gap between transfers.
    bit no_gaps = 1'b0;

    always #2 i_clk = ~i_clk;

    point_in_triangle_test #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_a_z       (i_a_z),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_b_z       (i_b_z),
        .i_c_x       (i_c_x),
        .i_c_y       (i_c_y),
        .i_c_z       (i_c_z),
        .i_p_x       (i_p_x),
        .i_p_y       (i_p_y),
        .i_p_z       (i_p_z),
        .o_strobe    (o_strobe),
        .o_inside_res(o_inside_res),
        .o_degenerate(o_degenerate)
    );

    // The checker sits beside the block, watches both channels, predicts
    // every verdict and compares. It hands back its failure count and the
    // number of verdicts still outstanding.
    pit_result_checker #(
        .CW(CW)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_a_z       (i_a_z),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_b_z       (i_b_z),
        .i_c_x       (i_c_x),
        .i_c_y       (i_c_y),
        .i_c_z       (i_c_z),
        .i_p_x       (i_p_x),
        .i_p_y       (i_p_y),
        .i_p_z       (i_p_z),
        .o_strobe    (o_strobe),
        .o_inside_res(o_inside_res),
        .o_degenerate(o_degenerate),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Watchdog. The cap lies far above the length of a correct run, so it
    // only trips when the block hangs or drops results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // A uniformly random value in [-span, span].
    function automatic int pick_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Presents one query and holds it until the block takes it. A transfer
    // happens at the edge where start is high and busy is low. Now and then
    // the sender drops start first, so gaps land at random points of the
    // pipeline's schedule. The next query reuses the step of the previous
    // transfer, so start stays high across back-to-back items.
    task automatic send_query(
        input int ax, input int ay, input int az,
        input int bx, input int by, input int bz,
        input int cx, input int cy, input int cz,
        input int px, input int py, input int pz);
        if (!no_gaps && $urandom_range(0, 99) < 3) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_a_x <= t_coord'(ax);  i_a_y <= t_coord'(ay);  i_a_z <= t_coord'(az);
        i_b_x <= t_coord'(bx);  i_b_y <= t_coord'(by);  i_b_z <= t_coord'(bz);
        i_c_x <= t_coord'(cx);  i_c_y <= t_coord'(cy);  i_c_z <= t_coord'(cz);
        i_p_x <= t_coord'(px);  i_p_y <= t_coord'(py);  i_p_z <= t_coord'(pz);
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Builds one random query of the given kind.
    task automatic send_random(input t_gen_kind kind);
        int a[3], u[3], v[3], p[3];
        int s, t, k;
        case (kind)
            GEN_FULL: begin
                // Raw 16-bit patterns, so every bit of every field toggles.
                send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            GEN_TINY: begin
                // Tiny lattice: lots of boundary hits, zero dot products and
                // accidental zero-area triangles.
                for (int i = 0; i < 3; i++) begin
                    a[i] = pick_span(6);
                    u[i] = pick_span(6);
                    v[i] = pick_span(6);
                    p[i] = pick_span(6);
                end
                send_query(a[0], a[1], a[2], u[0], u[1], u[2],
                           v[0], v[1], v[2], p[0], p[1], p[2]);
            end
            GEN_PLANAR: begin
                // The point is an exact convex combination of the corners,
                // so it lies inside or on the border. Edge vectors are
                // multiples of 16 so the weights divide out exactly. A
                // quarter of these get nudged one unit off the plane.
                s = $urandom_range(0, 16);
                t = $urandom_range(0, 16 - s);
                for (int i = 0; i < 3; i++) begin
                    a[i] = pick_span(8000);
                    u[i] = 16 * pick_span(500);
                    v[i] = 16 * pick_span(500);
                    p[i] = a[i] + (s * u[i] + t * v[i]) / 16;
                end
                if ($urandom_range(0, 3) == 0)
                    p[$urandom_range(0, 2)] += ($urandom_range(0, 1) != 0) ? 1 : -1;
                send_query(a[0], a[1], a[2],
                           a[0] + u[0], a[1] + u[1], a[2] + u[2],
                           a[0] + v[0], a[1] + v[1], a[2] + v[2],
                           p[0], p[1], p[2]);
            end
            default: begin
                // Collinear corners: C on the line through A and B.
                k = pick_span(3);
                for (int i = 0; i < 3; i++) begin
                    a[i] = pick_span(1000);
                    u[i] = pick_span(1000);
                    p[i] = pick_span(CMAX);
                end
                send_query(a[0], a[1], a[2],
                           a[0] + u[0], a[1] + u[1], a[2] + u[2],
                           a[0] + k * u[0], a[1] + k * u[1], a[2] + k * u[2],
                           p[0], p[1], p[2]);
            end
        endcase
    endtask

    initial begin
        int roll;
        t_gen_kind kind;

        // Synchronous reset is held at the start and never asserted again.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Every corner at zero, two corners that coincide and
        // three collinear corners give a zero-area triangle.
        send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_query(3, -4, 5, 3, -4, 5, 9, 1, -2, 3, -4, 5);
        send_query(0, 0, 0, 5, 5, 5, -7, -7, -7, 1, 1, 1);
        send_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0);
        send_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                   CMAX, CMAX, CMAX);

        // A right triangle in the z = 0 plane and points around it: strictly
        // inside, on a corner, on a leg where one dot product is zero, on
        // the hypotenuse, just past it, behind a leg, and off the plane.
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 3, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 0, 0, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 5, 0, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 0, 7, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 5, 5, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 6, 6, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, -1, 2, 0);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, 5);
        send_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, -1);

        // A tilted triangle with a point next to its centroid and with a far point.
        send_query(1, 2, 3, 101, -50, 7, -30, 80, 200, 24, 11, 70);
        send_query(1, 2, 3, 101, -50, 7, -30, 80, 200, -500, 900, 3);

        // Full-scale corners push most products to their widest.
        send_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX,
                   CMAX, CMAX, CMAX);
        send_query(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN,
                   CMIN, CMIN, CMIN);
        send_query(CMIN, 0, CMAX, CMAX, CMIN, 0, 0, CMAX, CMIN, 0, 0, 0);
        send_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX,
                   CMIN, CMAX, CMAX);
        send_query(CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, 0, 0, 0);
        send_query(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0);

        // Random part. Most queries are built so the point sits in or near
        // the triangle, since fully random points almost never land inside.
        // A long run in the middle goes without any sender gaps.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            no_gaps = (n >= 150 && n < 280);
            roll = $urandom_range(0, 9);
            if (roll < 3)
                kind = GEN_FULL;
            else if (roll < 5)
                kind = GEN_TINY;
            else if (roll < 9)
                kind = GEN_PLANAR;
            else
                kind = GEN_FLAT;
            send_random(kind);
        end

        // Drain. The first wait also lets the checker's count catch up with
        // the last transfer. Then give the pipeline a full latency more so a
        // stray strobe after the last verdict is still caught.
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (PIPE_LAT + 8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
